### design/assert_macros.svh
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MBSDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define MBSDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/mbsdm_pkg.sv
package mbsdm_pkg;

    // store sizes are powers of two; addresses wrap by masking
    localparam int COIL_BYTES     = 32;
    localparam int DISCRETE_BYTES = 32;
    localparam int HOLD_REGS      = 64;
    localparam int INPUT_REGS     = 64;
    localparam int MAX_QTY        = 32;

    localparam int COIL_BITS = COIL_BYTES * 8;
    localparam int DISC_BITS = DISCRETE_BYTES * 8;

    localparam int MAXN_A = (COIL_BITS > DISC_BITS) ? COIL_BITS : DISC_BITS;
    localparam int MAXN_B = (HOLD_REGS > INPUT_REGS) ? HOLD_REGS : INPUT_REGS;
    localparam int MAXN   = (MAXN_A > MAXN_B) ? MAXN_A : MAXN_B;
    // wide enough for any store size or index
    localparam int SZ_W   = $clog2(MAXN + 1);
    localparam int Q_W    = $clog2(MAX_QTY + 1);
    localparam int DVD_W  = 17;

    localparam int COIL_AW = (COIL_BYTES > 1) ? $clog2(COIL_BYTES) : 1;
    localparam int DISC_AW = (DISCRETE_BYTES > 1) ? $clog2(DISCRETE_BYTES) : 1;
    localparam int HOLD_AW = (HOLD_REGS > 1) ? $clog2(HOLD_REGS) : 1;
    localparam int INP_AW  = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;

    typedef enum logic [3:0] {
        FN_RD_COIL  = 4'd0,
        FN_RD_DISC  = 4'd1,
        FN_RD_HOLD  = 4'd2,
        FN_RD_INREG = 4'd3,
        FN_WR_COIL  = 4'd4,
        FN_WR_REG   = 4'd5,
        FN_WR_MULTI = 4'd6,
        FN_LD_DISC  = 4'd7,
        FN_LD_INREG = 4'd8
    } func_t;

    localparam logic [7:0] RC_RD_COIL  = 8'd1;
    localparam logic [7:0] RC_RD_DISC  = 8'd2;
    localparam logic [7:0] RC_RD_HOLD  = 8'd3;
    localparam logic [7:0] RC_RD_INREG = 8'd4;
    localparam logic [7:0] RC_WR_COIL  = 8'd5;
    localparam logic [7:0] RC_WR_REG   = 8'd6;
    localparam logic [7:0] RC_WR_MULTI = 8'd16;
    localparam logic [7:0] RC_NONE     = 8'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MOD,
        ST_HDR,
        ST_RDA,
        ST_RDB,
        ST_EMIT,
        ST_WR_ECHO
    } state_t;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic init;
        logic rd;
        logic rd_hi;
        logic lo_cap;
        logic wr;
        logic adv;
        logic push_hdr;
        logic push_pay;
        logic push_echo;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  out_free;
        logic  off_lt_q;
        logic  last_word;
        logic  cnt_zero;
        logic  pay_last;
    } stat_t;

    function automatic logic [7:0] resp_code_of(func_t f);
        logic [7:0] c;
        case (f)
            FN_RD_COIL:  c = RC_RD_COIL;
            FN_RD_DISC:  c = RC_RD_DISC;
            FN_RD_HOLD:  c = RC_RD_HOLD;
            FN_RD_INREG: c = RC_RD_INREG;
            FN_WR_COIL:  c = RC_WR_COIL;
            FN_WR_REG:   c = RC_WR_REG;
            FN_WR_MULTI: c = RC_WR_MULTI;
            default:     c = RC_NONE;
        endcase
        return c;
    endfunction

endpackage

### design/mbsdm_ram.sv
module mbsdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mbsdm_ctrl.sv
module mbsdm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mbsdm_pkg::stat_t  stat,
    output mbsdm_pkg::cmd_t   cmd
);
    import mbsdm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // unused codes are dropped here
                if (stat.func inside {[FN_RD_COIL:FN_LD_INREG]}) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD: begin
                cmd.init = 1'b1;
                case (stat.func)
                    FN_RD_COIL, FN_RD_DISC, FN_RD_HOLD, FN_RD_INREG:
                        state_next = ST_HDR;
                    FN_WR_COIL, FN_LD_DISC:
                        state_next = ST_RDA;
                    FN_WR_REG, FN_LD_INREG:
                        state_next = ST_WR_ECHO;
                    FN_WR_MULTI: begin
                        if (stat.off_lt_q || stat.last_word) begin
                            state_next = ST_WR_ECHO;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_HDR: begin
                if (stat.out_free) begin
                    cmd.push_hdr = 1'b1;
                    state_next   = stat.cnt_zero ? ST_IDLE : ST_RDA;
                end
            end
            ST_RDA: begin
                cmd.rd = 1'b1;
                case (stat.func)
                    FN_RD_COIL, FN_RD_DISC:    state_next = ST_RDB;
                    FN_RD_HOLD, FN_RD_INREG:   state_next = ST_EMIT;
                    default:                   state_next = ST_WR_ECHO;
                endcase
            end
            ST_RDB: begin
                cmd.lo_cap = 1'b1;
                cmd.rd     = 1'b1;
                cmd.rd_hi  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.push_pay = 1'b1;
                    cmd.adv      = 1'b1;
                    state_next   = stat.pay_last ? ST_IDLE : ST_RDA;
                end
            end
            ST_WR_ECHO: begin
                // store write where due, and the echo where the function has one
                if (stat.func inside {FN_LD_DISC, FN_LD_INREG}) begin
                    cmd.wr     = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.func == FN_WR_MULTI && !stat.last_word) begin
                    cmd.wr     = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.wr        = (stat.func != FN_WR_MULTI) || stat.off_lt_q;
                    cmd.push_echo = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/mbsdm_dp.sv
module mbsdm_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  mbsdm_pkg::cmd_t   cmd,
    output mbsdm_pkg::stat_t  stat,
    input  logic [3:0]        s_func,
    input  logic [7:0]        s_slave_addr,
    input  logic [15:0]       s_start_addr,
    input  logic [15:0]       s_quantity,
    input  logic [15:0]       s_value,
    input  logic              s_last_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_resp_slave,
    output logic [7:0]        m_resp_code,
    output logic              m_is_header,
    output logic [7:0]        m_byte_count,
    output logic [15:0]       m_echo_addr,
    output logic [15:0]       m_echo_value,
    output logic [15:0]       m_data,
    output logic              m_last
);
    import mbsdm_pkg::*;

    // request
    func_t           func_reg;
    logic [7:0]      slave_reg;
    logic [15:0]     start_reg;
    logic [Q_W-1:0]  q_reg;
    logic [15:0]     value_reg;
    logic            lastw_reg;
    logic [Q_W-1:0]  off_reg;

    // wrapped address
    logic [DVD_W-1:0] rem_reg;

    // walk
    logic [SZ_W-1:0] idx_reg;
    logic [Q_W-1:0]  cnt_reg;
    logic [7:0]      lo_reg;

    // result word
    logic            m_valid_reg;
    logic [7:0]      slave_out_reg, code_out_reg, bc_out_reg;
    logic            hdr_out_reg, last_out_reg;
    logic [15:0]     ea_out_reg, ev_out_reg, data_out_reg;

    logic sel_coil, sel_disc, sel_hold, sel_inp, is_bits;
    logic [SZ_W-1:0] div_sel, size_sel, idx_nxt, rd_addr;
    logic            out_free;

    assign sel_coil = (func_reg == FN_RD_COIL) || (func_reg == FN_WR_COIL);
    assign sel_disc = (func_reg == FN_RD_DISC) || (func_reg == FN_LD_DISC);
    assign sel_hold = (func_reg == FN_RD_HOLD) || (func_reg == FN_WR_REG)
                   || (func_reg == FN_WR_MULTI);
    assign sel_inp  = (func_reg == FN_RD_INREG) || (func_reg == FN_LD_INREG);
    assign is_bits  = sel_coil || sel_disc;

    always_comb begin
        if (sel_coil) begin
            div_sel  = SZ_W'(COIL_BITS);
            size_sel = SZ_W'(COIL_BYTES);
        end else if (sel_disc) begin
            div_sel  = SZ_W'(DISC_BITS);
            size_sel = SZ_W'(DISCRETE_BYTES);
        end else if (sel_hold) begin
            div_sel  = SZ_W'(HOLD_REGS);
            size_sel = SZ_W'(HOLD_REGS);
        end else begin
            div_sel  = SZ_W'(INPUT_REGS);
            size_sel = SZ_W'(INPUT_REGS);
        end
    end

    assign idx_nxt = (idx_reg == size_sel - SZ_W'(1)) ? '0 : idx_reg + SZ_W'(1);
    assign rd_addr = cmd.rd_hi ? idx_nxt : idx_reg;

    // stores
    logic [7:0]  coil_rd, disc_rd, coil_q, disc_q, bit_wr_byte;
    logic [15:0] hold_rd, inp_rd, hold_q, inp_q, sel_q;
    logic [COIL_BYTES-1:0]     coil_v_reg;
    logic [DISCRETE_BYTES-1:0] disc_v_reg;
    logic [HOLD_REGS-1:0]      hold_v_reg;
    logic [INPUT_REGS-1:0]     inp_v_reg;
    logic coil_vq_reg, disc_vq_reg, hold_vq_reg, inp_vq_reg;

    mbsdm_ram #(.WIDTH(8), .DEPTH(COIL_BYTES)) u_coil (
        .aclk(aclk), .we(cmd.wr && sel_coil), .waddr(idx_reg[COIL_AW-1:0]),
        .wdata(bit_wr_byte), .re(cmd.rd && sel_coil),
        .raddr(rd_addr[COIL_AW-1:0]), .rdata(coil_rd));
    mbsdm_ram #(.WIDTH(8), .DEPTH(DISCRETE_BYTES)) u_disc (
        .aclk(aclk), .we(cmd.wr && sel_disc), .waddr(idx_reg[DISC_AW-1:0]),
        .wdata(bit_wr_byte), .re(cmd.rd && sel_disc),
        .raddr(rd_addr[DISC_AW-1:0]), .rdata(disc_rd));
    mbsdm_ram #(.WIDTH(16), .DEPTH(HOLD_REGS)) u_hold (
        .aclk(aclk), .we(cmd.wr && sel_hold), .waddr(idx_reg[HOLD_AW-1:0]),
        .wdata(value_reg), .re(cmd.rd && sel_hold),
        .raddr(rd_addr[HOLD_AW-1:0]), .rdata(hold_rd));
    mbsdm_ram #(.WIDTH(16), .DEPTH(INPUT_REGS)) u_inp (
        .aclk(aclk), .we(cmd.wr && sel_inp), .waddr(idx_reg[INP_AW-1:0]),
        .wdata(value_reg), .re(cmd.rd && sel_inp),
        .raddr(rd_addr[INP_AW-1:0]), .rdata(inp_rd));

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coil_v_reg <= '0;
            disc_v_reg <= '0;
            hold_v_reg <= '0;
            inp_v_reg  <= '0;
        end else if (cmd.wr) begin
            if (sel_coil) coil_v_reg[idx_reg[COIL_AW-1:0]] <= 1'b1;
            if (sel_disc) disc_v_reg[idx_reg[DISC_AW-1:0]] <= 1'b1;
            if (sel_hold) hold_v_reg[idx_reg[HOLD_AW-1:0]] <= 1'b1;
            if (sel_inp)  inp_v_reg[idx_reg[INP_AW-1:0]]   <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd && sel_coil) coil_vq_reg <= coil_v_reg[rd_addr[COIL_AW-1:0]];
        if (cmd.rd && sel_disc) disc_vq_reg <= disc_v_reg[rd_addr[DISC_AW-1:0]];
        if (cmd.rd && sel_hold) hold_vq_reg <= hold_v_reg[rd_addr[HOLD_AW-1:0]];
        if (cmd.rd && sel_inp)  inp_vq_reg  <= inp_v_reg[rd_addr[INP_AW-1:0]];
    end

    assign coil_q = coil_vq_reg ? coil_rd : '0;
    assign disc_q = disc_vq_reg ? disc_rd : '0;
    assign hold_q = hold_vq_reg ? hold_rd : '0;
    assign inp_q  = inp_vq_reg  ? inp_rd  : '0;

    always_comb begin
        if (sel_coil)      sel_q = {8'h00, coil_q};
        else if (sel_disc) sel_q = {8'h00, disc_q};
        else if (sel_hold) sel_q = hold_q;
        else               sel_q = inp_q;
    end

    // single-bit update
    logic       bval;
    logic [7:0] bmask_wr;
    assign bval        = (func_reg == FN_WR_COIL) ? (|value_reg[15:8]) : (|value_reg);
    assign bmask_wr    = 8'h01 << rem_reg[2:0];
    assign bit_wr_byte = bval ? (sel_q[7:0] | bmask_wr) : (sel_q[7:0] & ~bmask_wr);

    // packed byte from two neighbor store bytes
    logic [15:0] pair;
    logic [7:0]  keep, byte_out;
    assign pair     = {sel_q[7:0], lo_reg} >> rem_reg[2:0];
    assign keep     = (cnt_reg >= Q_W'(8)) ? 8'hFF : ((8'h01 << cnt_reg[2:0]) - 8'h01);
    assign byte_out = pair[7:0] & keep;

    logic [7:0] hdr_bc;
    assign hdr_bc = is_bits ? 8'((q_reg + Q_W'(0) + 7) >> 3) : 8'({q_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= func_t'(s_func);
            slave_reg <= s_slave_addr;
            start_reg <= s_start_addr;
            q_reg     <= (s_quantity > 16'(MAX_QTY)) ? Q_W'(MAX_QTY) : s_quantity[Q_W-1:0];
            value_reg <= s_value;
            lastw_reg <= s_last_word;
        end
        if (cmd.lo_cap) begin
            lo_reg <= sel_q[7:0];
        end
        if (cmd.init) begin
            idx_reg <= is_bits ? SZ_W'(rem_reg >> 3) : SZ_W'(rem_reg);
            cnt_reg <= q_reg;
        end else if (cmd.adv) begin
            idx_reg <= idx_nxt;
            if (is_bits) cnt_reg <= (cnt_reg > Q_W'(8)) ? cnt_reg - Q_W'(8) : '0;
            else         cnt_reg <= cnt_reg - Q_W'(1);
        end
        // wrap to the store size with a mask
        if (cmd.mod_start) begin
            rem_reg <= ({1'b0, start_reg}
                      + ((func_reg == FN_WR_MULTI) ? DVD_W'(off_reg) : '0))
                     & DVD_W'(div_sel - SZ_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (func_reg == FN_WR_MULTI) begin
                if (cmd.push_echo)   off_reg <= '0;
                else if (cmd.wr)     off_reg <= off_reg + Q_W'(1);
            end

            if (cmd.push_hdr || cmd.push_pay || cmd.push_echo) m_valid_reg <= 1'b1;
            else if (m_ready)                                  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_hdr || cmd.push_pay || cmd.push_echo) begin
            slave_out_reg <= slave_reg;
            code_out_reg  <= resp_code_of(func_reg);
            hdr_out_reg   <= !cmd.push_pay;
            bc_out_reg    <= cmd.push_hdr ? hdr_bc : 8'h00;
            ea_out_reg    <= cmd.push_echo ? start_reg : 16'h0000;
            ev_out_reg    <= !cmd.push_echo ? 16'h0000
                           : (func_reg == FN_WR_MULTI) ? 16'(q_reg) : value_reg;
            data_out_reg  <= !cmd.push_pay ? 16'h0000
                           : is_bits ? {8'h00, byte_out} : sel_q;
            last_out_reg  <= cmd.push_echo || (cmd.push_hdr && stat.cnt_zero)
                           || (cmd.push_pay && stat.pay_last);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    assign stat.func      = func_reg;
    assign stat.out_free  = out_free;
    assign stat.off_lt_q  = off_reg < q_reg;
    assign stat.last_word = lastw_reg;
    assign stat.cnt_zero  = cnt_reg == '0;
    assign stat.pay_last  = is_bits ? (cnt_reg <= Q_W'(8)) : (cnt_reg == Q_W'(1));

    assign m_valid      = m_valid_reg;
    assign m_resp_slave = slave_out_reg;
    assign m_resp_code  = code_out_reg;
    assign m_is_header  = hdr_out_reg;
    assign m_byte_count = bc_out_reg;
    assign m_echo_addr  = ea_out_reg;
    assign m_echo_value = ev_out_reg;
    assign m_data       = data_out_reg;
    assign m_last       = last_out_reg;

endmodule

### design/modbus_slave_data_model.sv
// Modbus slave data model for function codes 1-6 and 16 (no framing, no CRC).
// One request word in, zero or more response words out, one request at a time.
// After a request word is taken, the PREP state wraps its address to the
// addressed store by masking (store sizes are powers of two) and the MOD state
// sets up the walk before the first response word is loaded. A register read
// then gives one word per RAM read, a coil/discrete read one packed byte per
// two neighbor store bytes, which are read and merged at the bit offset. A
// coil write or discrete load reads the store byte and updates a single bit;
// a data word of a multiple write past the quantity is not written, and an
// unused code is dropped without a response. A stalled m_ready holds the
// sequence. Stores read as zero after reset through per-entry valid flags, so
// no clearing pass is needed.
module modbus_slave_data_model (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [7:0]  s_slave_addr,
    input  logic [15:0] s_start_addr,
    input  logic [15:0] s_quantity,
    input  logic [15:0] s_value,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_resp_slave,
    output logic [7:0]  m_resp_code,
    output logic        m_is_header,
    output logic [7:0]  m_byte_count,
    output logic [15:0] m_echo_addr,
    output logic [15:0] m_echo_value,
    output logic [15:0] m_data,
    output logic        m_last
);
    import mbsdm_pkg::*;

    `include "assert_macros.svh"

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    mbsdm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    // request registers, address wrap, stores, result word
    mbsdm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .s_func(s_func), .s_slave_addr(s_slave_addr),
        .s_start_addr(s_start_addr), .s_quantity(s_quantity),
        .s_value(s_value), .s_last_word(s_last_word),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_resp_slave(m_resp_slave), .m_resp_code(m_resp_code),
        .m_is_header(m_is_header), .m_byte_count(m_byte_count),
        .m_echo_addr(m_echo_addr), .m_echo_value(m_echo_value),
        .m_data(m_data), .m_last(m_last)
    );

    // a result word is only loaded when the output register can take it
    `MBSDM_ASSERT_NOW(a_push_free, cmd.push_hdr || cmd.push_pay || cmd.push_echo, stat.out_free)
    // at most one push per cycle
    `MBSDM_ASSERT_NOW(a_push_one, 1'b1, $onehot0({cmd.push_hdr, cmd.push_pay, cmd.push_echo}))
    // nothing is pushed while waiting for a request
    `MBSDM_ASSERT_NOW(a_idle_quiet, s_ready, !(cmd.push_hdr || cmd.push_pay || cmd.push_echo))
    // a taken request closes the input on the next cycle
    `MBSDM_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready)

endmodule
